// ===== hdl/ccwi_pkg.sv =====
// Shared types and constants for the closed contour weighted integral.
// No dependencies.
package ccwi_pkg;

  localparam logic signed [31:0] FSlopeReset = 32'sd9472;
  localparam logic signed [31:0] PsiRefReset = 32'sd84452;
  localparam logic signed [31:0] FRefReset   = -32'sd2153513;
  localparam logic [31:0]        InvTwoPiQ32 = 32'd683565276;
  localparam logic [46:0]        WMaxMag     = {47{1'b1}};

  typedef enum logic [1:0] {
    REG_F_SLOPE = 2'd0,
    REG_PSI_REF = 2'd1,
    REG_F_REF   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_MUL,
    ST_F_ADD,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_DONE,
    ST_SEG_INIT,
    ST_SQRT,
    ST_TERM_MUL,
    ST_TERM_MUL_HI,
    ST_TERM_ADD,
    ST_Q_MUL,
    ST_Q_MUL_HI,
    ST_Q_DONE,
    ST_OUT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;   // capture input and start a new contour if needed
    logic f_mul;
    logic f_add;
    logic div_init;
    logic div_step;
    logic div_done;
    logic seg_init;    // set up segment; close_seg picks first point as end
    logic close_seg;
    logic sqrt_step;
    logic term_mul;    // low half of the weight sum times length
    logic term_mul_hi; // high half, added on
    logic term_add;
    logic q_mul;       // low word of |sum| times 1/(2*pi)
    logic q_mul_hi;    // high word, added on
    logic q_done;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic first;       // item opened a contour
    logic last;
    logic div_last;
    logic sqrt_last;
  } sts_t;

endpackage

// ===== hdl/ccwi_if.sv =====
// Valid/ready channel interfaces for the contour integral block.
// Depends on nothing.
interface ccwi_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [23:0] r_coord;
  logic signed [23:0] z_coord;
  logic signed [31:0] psi_level;
  logic        last_point;
  modport source (output valid, r_coord, z_coord, psi_level, last_point, input ready);
  modport sink   (input valid, r_coord, z_coord, psi_level, last_point, output ready);
endinterface

interface ccwi_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic signed [31:0] q_value;
  logic        zero_radius;
  logic        saturated;
  modport source (output valid, q_value, zero_radius, saturated, input ready);
  modport sink   (input valid, q_value, zero_radius, saturated, output ready);
endinterface

interface ccwi_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ccwi_ctrl.sv =====
// Controller state machine for the contour integral.
// Depends on ccwi_pkg.
module ccwi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ccwi_pkg::sts_t  sts,
  output ccwi_pkg::cmd_t  cmd
);
  import ccwi_pkg::*;

  state_t state, state_next;
  logic   closing, closing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      closing <= 1'b0;
    end else begin
      state   <= state_next;
      closing <= closing_next;
    end
  end

  always_comb begin
    state_next   = state;
    closing_next = closing;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          closing_next  = 1'b0;
          state_next    = ST_F_MUL;
        end
      end
      ST_F_MUL: begin
        if (sts.first) begin
          cmd.f_mul  = 1'b1;
          state_next = ST_F_ADD;
        end else begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_F_ADD: begin
        cmd.f_add  = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        cmd.div_done = 1'b1;
        if (!sts.first) begin
          state_next = ST_SEG_INIT;
        end else if (sts.last) begin
          closing_next = 1'b1;
          state_next   = ST_SEG_INIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEG_INIT: begin
        cmd.seg_init  = 1'b1;
        cmd.close_seg = closing;
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_next = ST_TERM_MUL;
      end
      ST_TERM_MUL: begin
        cmd.term_mul = 1'b1;
        state_next   = ST_TERM_MUL_HI;
      end
      ST_TERM_MUL_HI: begin
        cmd.term_mul_hi = 1'b1;
        state_next      = ST_TERM_ADD;
      end
      ST_TERM_ADD: begin
        cmd.term_add = 1'b1;
        if (closing) begin
          state_next = ST_Q_MUL;
        end else if (sts.last) begin
          closing_next = 1'b1;
          state_next   = ST_SEG_INIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_MUL: begin
        cmd.q_mul  = 1'b1;
        state_next = ST_Q_MUL_HI;
      end
      ST_Q_MUL_HI: begin
        cmd.q_mul_hi = 1'b1;
        state_next   = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        cmd.q_done = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_in_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("input taken outside idle");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_item, cmd.f_mul, cmd.div_step, cmd.sqrt_step, cmd.term_add,
              cmd.q_done})) else $error("overlapping commands");
`endif
endmodule

// ===== hdl/ccwi_dp.sv =====
// Datapath for the contour integral: f, weight divider, sqrt, sum, scale.
// Depends on ccwi_pkg.
module ccwi_dp #(
  parameter int FracBits = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ccwi_pkg::cmd_t      cmd,
  output ccwi_pkg::sts_t      sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [23:0]         in_r,
  input  logic signed [23:0]  in_z,
  input  logic signed [31:0]  in_psi,
  input  logic                in_last,
  output logic signed [31:0]  q_value,
  output logic                zero_radius,
  output logic                saturated
);
  import ccwi_pkg::*;

  localparam int DivBits = 32 + 2 * FracBits;   // dividend bit count
  localparam int DivCntW = $clog2(DivBits);
  localparam int TermSh  = FracBits + 1;

  logic signed [31:0] f_slope, psi_ref, f_ref;
  logic [23:0]        first_r, prev_r, cur_r;
  logic signed [23:0] first_z, prev_z, cur_z;
  logic signed [47:0] first_weight, prev_weight, cur_weight;
  logic signed [63:0] running_sum;
  logic signed [31:0] contour_f;
  logic               in_contour, error_seen, clip_seen, first, last;
  logic signed [32:0] dpsi;
  logic signed [64:0] fprod;

  // divider
  logic [47:0]        divisor;
  logic [DivBits-1:0] dividend;
  logic [48:0]        rem;
  logic [46:0]        quo;
  logic               div_over;
  logic [DivCntW-1:0] div_cnt;

  // sqrt
  logic [48:0] sq_n, sq_res, sq_bit;
  logic [4:0]  sq_cnt;
  logic signed [48:0] seg_ws;
  logic [73:0] tprod;
  logic [95:0] qprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_slope <= FSlopeReset;
      psi_ref <= PsiRefReset;
      f_ref   <= FRefReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_F_SLOPE: f_slope <= cfg_data;
        REG_PSI_REF: psi_ref <= cfg_data;
        REG_F_REF:   f_ref   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [48:0] rem_sh;
  logic        rem_ge;
  logic signed [64:0] fsum;
  logic [23:0] ra, rb;
  logic signed [24:0] dr, dz;
  logic [24:0] adr, adz;
  logic [48:0] sq_t;
  logic [47:0] tmag;
  logic signed [64:0] sum_new;
  logic [63:0] smag;
  logic [63:0] tval;
  logic        q_clip;

  always_comb begin
    rem_sh = {rem[47:0], (div_cnt >= DivCntW'(2 * FracBits))
              ? dividend[div_cnt] : 1'b0};
    rem_ge = rem_sh >= {1'b0, divisor};
    fsum   = 65'(f_ref) + (fprod >>> FracBits);
    ra     = prev_r;
    rb     = cmd.close_seg ? first_r : cur_r;
    dr     = 25'(rb) - 25'(ra);
    dz     = cmd.close_seg ? 25'(first_z) - 25'(prev_z) : 25'(cur_z) - 25'(prev_z);
    adr    = dr < 0 ? 25'(-dr) : 25'(dr);
    adz    = dz < 0 ? 25'(-dz) : 25'(dz);
    sq_t   = sq_res + sq_bit;
    tmag   = 48'(seg_ws < 0 ? -seg_ws : seg_ws);
    tval   = 64'(tprod >> TermSh);
    sum_new = 65'(running_sum) + (seg_ws < 0 ? -65'(tval) : 65'(tval));
    smag   = running_sum < 0 ? 64'(-running_sum) : 64'(running_sum);
    // magnitude limit is 2^31 for a negative sum, 2^31-1 otherwise
    q_clip = running_sum < 0 ? (qprod[95:32] > 64'h8000_0000)
                             : (qprod[95:32] > 64'h7fff_ffff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_contour   <= 1'b0;
      div_cnt      <= '0;
      sq_cnt       <= '0;
      first        <= 1'b0;
      last         <= 1'b0;
      first_r      <= '0;
      first_z      <= '0;
      first_weight <= '0;
      prev_r       <= '0;
      prev_z       <= '0;
      prev_weight  <= '0;
      running_sum  <= '0;
      contour_f    <= '0;
      error_seen   <= 1'b0;
      clip_seen    <= 1'b0;
      q_value      <= '0;
    end else begin
      if (cmd.load_item) begin
        cur_r <= in_r;
        cur_z <= in_z;
        last  <= in_last;
        first <= !in_contour;
        in_contour <= !in_last;
        if (!in_contour) begin
          error_seen  <= 1'b0;
          clip_seen   <= 1'b0;
          running_sum <= '0;
          dpsi        <= 33'(in_psi) - 33'(psi_ref);
        end
      end
      if (cmd.f_mul) fprod <= 65'(f_slope) * 65'(dpsi);
      if (cmd.f_add) begin
        if (fsum > 65'sd2147483647) begin
          contour_f <= 32'sh7fffffff; clip_seen <= 1'b1;
        end else if (fsum < -65'sd2147483648) begin
          contour_f <= 32'sh80000000; clip_seen <= 1'b1;
        end else begin
          contour_f <= fsum[31:0];
        end
      end
      if (cmd.div_init) begin
        divisor  <= 48'(cur_r) * 48'(cur_r);
        dividend <= DivBits'(contour_f < 0 ? -33'(contour_f) : 33'(contour_f))
                    << (2 * FracBits);
        rem      <= '0;
        quo      <= '0;
        div_over <= 1'b0;
        div_cnt  <= DivCntW'(DivBits - 1);
      end
      if (cmd.div_step) begin
        rem <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
        if (rem_ge) begin
          if (div_cnt >= DivCntW'(47)) div_over <= 1'b1;
          else quo[div_cnt[5:0]] <= 1'b1;
        end
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.div_done) begin
        if (divisor == '0) begin
          cur_weight <= '0; error_seen <= 1'b1;
        end else if (div_over) begin
          clip_seen  <= 1'b1;
          cur_weight <= contour_f < 0 ? -48'(WMaxMag) : 48'(WMaxMag);
        end else begin
          cur_weight <= contour_f < 0 ? -48'(quo) : 48'(quo);
        end
        if (first) begin
          first_r <= cur_r; first_z <= cur_z;
          first_weight <= divisor == '0 ? '0 : (div_over
            ? (contour_f < 0 ? -48'(WMaxMag) : 48'(WMaxMag))
            : (contour_f < 0 ? -48'(quo) : 48'(quo)));
          prev_r <= cur_r; prev_z <= cur_z;
          prev_weight <= divisor == '0 ? '0 : (div_over
            ? (contour_f < 0 ? -48'(WMaxMag) : 48'(WMaxMag))
            : (contour_f < 0 ? -48'(quo) : 48'(quo)));
        end
      end
      if (cmd.seg_init) begin
        sq_n   <= 49'(adr) * 49'(adr) + 49'(adz) * 49'(adz);
        sq_res <= '0;
        sq_bit <= 49'(1) << 48;
        sq_cnt <= 5'd24;
        seg_ws <= 49'(prev_weight) + (cmd.close_seg ? 49'(first_weight) : 49'(cur_weight));
      end
      if (cmd.sqrt_step) begin
        if (sq_n >= sq_t) begin
          sq_n   <= sq_n - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 1'b1;
      end
      // |wa+wb| * length in two 24x25 halves
      if (cmd.term_mul) tprod <= 74'(tmag[23:0]) * 74'(sq_res[24:0]);
      if (cmd.term_mul_hi)
        tprod <= tprod + ((74'(tmag[47:24]) * 74'(sq_res[24:0])) << 24);
      if (cmd.term_add) begin
        if (!cmd.close_seg) begin
          prev_r <= cur_r; prev_z <= cur_z; prev_weight <= cur_weight;
        end
        if (sum_new > 65'sh0_7fff_ffff_ffff_ffff) begin
          running_sum <= 64'sh7fff_ffff_ffff_ffff; clip_seen <= 1'b1;
        end else if (sum_new < -65'sh0_8000_0000_0000_0000) begin
          running_sum <= 64'sh8000_0000_0000_0000; clip_seen <= 1'b1;
        end else begin
          running_sum <= sum_new[63:0];
        end
      end
      // |sum| * 1/(2*pi) as two 32x32 partial products
      if (cmd.q_mul) qprod <= 96'(smag[31:0]) * 96'(InvTwoPiQ32);
      if (cmd.q_mul_hi)
        qprod <= qprod + ((96'(smag[63:32]) * 96'(InvTwoPiQ32)) << 32);
      if (cmd.q_done) begin
        // clip flag counts even when a zero radius forces q to 0
        if (q_clip) clip_seen <= 1'b1;
        if (error_seen) begin
          q_value <= '0;
        end else if (q_clip) begin
          q_value <= running_sum < 0 ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          q_value <= running_sum < 0 ? -qprod[63:32] : qprod[63:32];
        end
      end
    end
  end

  assign zero_radius   = error_seen;
  assign saturated     = clip_seen;
  assign sts.first     = first;
  assign sts.last      = last;
  assign sts.div_last  = div_cnt == '0;
  assign sts.sqrt_last = sq_cnt == 5'd0;
endmodule

// ===== hdl/closed_contour_weighted_integral.sv =====
// Closed contour weighted line integral, top level.
// After the last point is taken, q follows its 64-step divider, the 25-step sqrt of
// each remaining segment (the closing segment included), and the scaling.
// Points are taken one at a time: no new point is accepted until the last one is done,
// including any output stall for a last point. Divider and sqrt iterations set the rate.
// Reset: rst synchronous active high; registers to defaults, waits for a first point.
module closed_contour_weighted_integral #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  ccwi_in_if.sink    in_ch,
  ccwi_out_if.source out_ch,
  ccwi_cfg_if.sink   cfg
);
  import ccwi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_valid;

  // Config always accepted; user keeps block idle when writes arrive, not enforced.
  assign cfg.ready = 1'b1;

  ccwi_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  ccwi_dp #(.FracBits(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .in_r       (in_ch.r_coord),
    .in_z       (in_ch.z_coord),
    .in_psi     (in_ch.psi_level),
    .in_last    (in_ch.last_point),
    .q_value    (out_ch.q_value),
    .zero_radius(out_ch.zero_radius),
    .saturated  (out_ch.saturated)
  );

  assign out_ch.valid = out_valid;
endmodule
